// ----- rtl/tsq_pkg.sv -----
package tsq_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);

    localparam int ID_W   = 16;
    localparam int DUR_W  = 32;
    localparam int TPS_W  = 16;
    localparam int TIME_W = 64;
    localparam int PROD_W = DUR_W + TPS_W;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(18);

    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_SLEEP_TCK = 2'd1,
        REQ_SLEEP_SEC = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_WOKEN    = 2'd2,
        KIND_IDLE     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MUL    = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_SCAN   = 4'b1000
    } state_t;

endpackage

// ----- rtl/tick_sleep_queue.sv -----
// A sleep request goes through capture, duration scaling on the one 32x16 multiplier, and
// saturating add and append, and gives one result. A tick first increments the counter, then
// the scan reads one slot per cycle through the single compare unit, compacting the list in
// place, and a closing step ends the scan.
// A woken task is held back until the next expired slot is found or the scan closes, so that
// the final beat of a tick can carry last. Results come out for one cycle each on
// result_valid and the receiver cannot stall them; busy is high from the accepted start until
// the final beat has been issued.
module tick_sleep_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   req_type,
    input  logic [tsq_pkg::ID_W-1:0]     task_id,
    input  logic [tsq_pkg::DUR_W-1:0]    duration,
    input  logic                         cfg_we,
    input  logic [tsq_pkg::TPS_W-1:0]    cfg_wdata,
    output logic                         result_valid,
    output logic [1:0]                   kind,
    output logic [tsq_pkg::ID_W-1:0]     woken_id,
    output logic [tsq_pkg::TIME_W-1:0]   tick_count,
    output logic                         last
);

    tsq_pkg::state_t                 state_reg, state_next;
    logic [tsq_pkg::TPS_W-1:0]       tps_reg, tps_next;
    logic [tsq_pkg::TIME_W-1:0]      counter_reg, counter_next;
    logic [tsq_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [tsq_pkg::CNT_W-1:0]       rd_reg, rd_next;
    logic [tsq_pkg::CNT_W-1:0]       wr_reg, wr_next;
    logic [tsq_pkg::RES_W-1:0]       woke_reg, woke_next;
    logic                            pend_reg, pend_next;
    logic [tsq_pkg::ID_W-1:0]        pend_id_reg, pend_id_next;
    logic                            sec_reg, sec_next;
    logic [tsq_pkg::ID_W-1:0]        id_reg, id_next;
    logic [tsq_pkg::DUR_W-1:0]       dur_reg, dur_next;
    logic [tsq_pkg::TIME_W-1:0]      len_reg, len_next;

    logic                            res_valid_reg, res_valid_next;
    logic [1:0]                      kind_reg, kind_next;
    logic [tsq_pkg::ID_W-1:0]        woken_id_reg, woken_id_next;
    logic                            last_reg, last_next;

    logic [tsq_pkg::ID_W-1:0]        slot_task_reg [tsq_pkg::LIST_DEPTH];
    logic [tsq_pkg::TIME_W-1:0]      slot_wake_reg [tsq_pkg::LIST_DEPTH];

    logic                            slot_we;
    logic [tsq_pkg::IDX_W-1:0]       slot_waddr;
    logic [tsq_pkg::ID_W-1:0]        slot_wtask;
    logic [tsq_pkg::TIME_W-1:0]      slot_wwake;

    logic [tsq_pkg::ID_W-1:0]        rd_task;
    logic [tsq_pkg::TIME_W-1:0]      rd_wake;
    logic [tsq_pkg::PROD_W-1:0]      product;
    logic [tsq_pkg::TIME_W:0]        wake_sum;
    logic                            expired;

    assign rd_task  = slot_task_reg[rd_reg[tsq_pkg::IDX_W-1:0]];
    assign rd_wake  = slot_wake_reg[rd_reg[tsq_pkg::IDX_W-1:0]];
    assign product  = dur_reg * tps_reg;
    assign wake_sum = {1'b0, counter_reg} + {1'b0, len_reg};
    assign expired  = (rd_wake <= counter_reg)
                   && (woke_reg < tsq_pkg::RES_W'(tsq_pkg::MAX_RESULTS));

    always_comb
    begin
        state_next     = state_reg;
        tps_next       = cfg_we ? cfg_wdata : tps_reg;
        counter_next   = counter_reg;
        count_next     = count_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        woke_next      = woke_reg;
        pend_next      = pend_reg;
        pend_id_next   = pend_id_reg;
        sec_next       = sec_reg;
        id_next        = id_reg;
        dur_next       = dur_reg;
        len_next       = len_reg;
        res_valid_next = 1'b0;
        kind_next      = kind_reg;
        woken_id_next  = woken_id_reg;
        last_next      = last_reg;
        slot_we        = 1'b0;
        slot_waddr     = rd_reg[tsq_pkg::IDX_W-1:0];
        slot_wtask     = rd_task;
        slot_wwake     = rd_wake;

        unique case (state_reg)
            tsq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    id_next  = task_id;
                    dur_next = duration;
                    sec_next = (req_type == tsq_pkg::REQ_SLEEP_SEC);
                    if (req_type == tsq_pkg::REQ_TICK)
                    begin
                        counter_next = counter_reg + tsq_pkg::TIME_W'(1);
                        rd_next      = '0;
                        wr_next      = '0;
                        woke_next    = '0;
                        pend_next    = 1'b0;
                        state_next   = tsq_pkg::ST_SCAN;
                    end
                    else if (req_type == tsq_pkg::REQ_SLEEP_TCK
                          || req_type == tsq_pkg::REQ_SLEEP_SEC)
                    begin
                        state_next = tsq_pkg::ST_MUL;
                    end
                end
            end
            tsq_pkg::ST_MUL:
            begin
                if (sec_reg)
                    len_next = tsq_pkg::TIME_W'(product);
                else
                    len_next = tsq_pkg::TIME_W'(dur_reg);
                state_next = tsq_pkg::ST_APPEND;
            end
            tsq_pkg::ST_APPEND:
            begin
                res_valid_next = 1'b1;
                woken_id_next  = '0;
                last_next      = 1'b1;
                if (count_reg == tsq_pkg::CNT_W'(tsq_pkg::LIST_DEPTH))
                begin
                    kind_next = tsq_pkg::KIND_REJECTED;
                end
                else
                begin
                    kind_next  = tsq_pkg::KIND_ACCEPTED;
                    slot_we    = 1'b1;
                    slot_waddr = count_reg[tsq_pkg::IDX_W-1:0];
                    slot_wtask = id_reg;
                    slot_wwake = wake_sum[tsq_pkg::TIME_W] ? '1
                               : wake_sum[tsq_pkg::TIME_W-1:0];
                    count_next = count_reg + tsq_pkg::CNT_W'(1);
                end
                state_next = tsq_pkg::ST_IDLE;
            end
            tsq_pkg::ST_SCAN:
            begin
                if (rd_reg == count_reg)
                begin
                    res_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (pend_reg)
                    begin
                        kind_next     = tsq_pkg::KIND_WOKEN;
                        woken_id_next = pend_id_reg;
                    end
                    else
                    begin
                        kind_next     = tsq_pkg::KIND_IDLE;
                        woken_id_next = '0;
                    end
                    pend_next  = 1'b0;
                    count_next = wr_reg;
                    state_next = tsq_pkg::ST_IDLE;
                end
                else
                begin
                    rd_next = rd_reg + tsq_pkg::CNT_W'(1);
                    if (expired)
                    begin
                        if (pend_reg)
                        begin
                            res_valid_next = 1'b1;
                            kind_next      = tsq_pkg::KIND_WOKEN;
                            woken_id_next  = pend_id_reg;
                            last_next      = 1'b0;
                        end
                        pend_next    = 1'b1;
                        pend_id_next = rd_task;
                        woke_next    = woke_reg + tsq_pkg::RES_W'(1);
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = wr_reg[tsq_pkg::IDX_W-1:0];
                        wr_next    = wr_reg + tsq_pkg::CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = tsq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsq_pkg::ST_IDLE;
            tps_reg       <= tsq_pkg::TPS_RESET;
            counter_reg   <= '0;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            woke_reg      <= '0;
            pend_reg      <= 1'b0;
            sec_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tps_reg       <= tps_next;
            counter_reg   <= counter_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            woke_reg      <= woke_next;
            pend_reg      <= pend_next;
            sec_reg       <= sec_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        id_reg       <= id_next;
        dur_reg      <= dur_next;
        len_reg      <= len_next;
        kind_reg     <= kind_next;
        woken_id_reg <= woken_id_next;
        last_reg     <= last_next;
        if (slot_we)
        begin
            slot_task_reg[slot_waddr] <= slot_wtask;
            slot_wake_reg[slot_waddr] <= slot_wwake;
        end
    end

    assign busy         = (state_reg != tsq_pkg::ST_IDLE);
    assign result_valid = res_valid_reg;
    assign kind         = kind_reg;
    assign woken_id     = woken_id_reg;
    assign tick_count   = counter_reg;
    assign last         = last_reg;

endmodule

// ----- tb/sv/tick_sleep_queue_tb.sv -----
`timescale 1ns / 100ps

module tick_sleep_queue_tb;

    import tsq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned SETTLE_CYCLES = 24;

    typedef struct {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  count;
        logic               last;
    } beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          req_type = REQ_TICK;
    logic [ID_W-1:0]     task_id = '0;
    logic [DUR_W-1:0]    duration = '0;
    logic                cfg_we = 1'b0;
    logic [TPS_W-1:0]    cfg_wdata = '0;
    logic                result_valid;
    logic [1:0]          kind;
    logic [ID_W-1:0]     woken_id;
    logic [TIME_W-1:0]   tick_count;
    logic                last;

    logic [TIME_W-1:0]   clock_now = '0;
    logic [TPS_W-1:0]    tps_now = TPS_RESET;
    logic [ID_W-1:0]     sleeper_id[$];
    logic [TIME_W-1:0]   sleeper_wake[$];
    beat_t               due_beats[$];
    int unsigned         mismatches = 0;
    int unsigned         cycle_count = 0;
    bit                  gaps_on = 1'b1;

    tick_sleep_queue dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .task_id      (task_id),
        .duration     (duration),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .kind         (kind),
        .woken_id     (woken_id),
        .tick_count   (tick_count),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tick_sleep_queue_tb: FAIL");
            $finish;
        end
    end

    function automatic void push_beat(kind_t k, logic [ID_W-1:0] id, logic fin);
        beat_t b;
        b.kind  = k;
        b.id    = id;
        b.count = clock_now;
        b.last  = fin;
        due_beats.push_back(b);
    endfunction

    function automatic void forecast_beats(req_t rt, logic [ID_W-1:0] id,
                                           logic [DUR_W-1:0] dur);
        beat_t            b;
        logic [TIME_W:0]  sum;
        logic [TIME_W-1:0] span;
        int               i;
        int               woke;
        case (rt)
            REQ_TICK:
            begin
                clock_now = clock_now + 1'b1;
                woke = 0;
                i = 0;
                while (i < sleeper_id.size() && woke < MAX_RESULTS)
                begin
                    if (sleeper_wake[i] <= clock_now)
                    begin
                        push_beat(KIND_WOKEN, sleeper_id[i], 1'b0);
                        sleeper_id.delete(i);
                        sleeper_wake.delete(i);
                        woke++;
                    end
                    else
                    begin
                        i++;
                    end
                end
                if (woke == 0)
                begin
                    push_beat(KIND_IDLE, '0, 1'b1);
                end
                else
                begin
                    b = due_beats.pop_back();
                    b.last = 1'b1;
                    due_beats.push_back(b);
                end
            end
            REQ_SLEEP_TCK, REQ_SLEEP_SEC:
            begin
                if (rt == REQ_SLEEP_SEC)
                    span = TIME_W'(dur) * TIME_W'(tps_now);
                else
                    span = TIME_W'(dur);
                sum = {1'b0, clock_now} + {1'b0, span};
                if (sleeper_id.size() >= LIST_DEPTH)
                begin
                    push_beat(KIND_REJECTED, '0, 1'b1);
                end
                else
                begin
                    sleeper_id.push_back(id);
                    sleeper_wake.push_back(sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0]);
                    push_beat(KIND_ACCEPTED, '0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : check_beats
        beat_t want;
        if (rst_n && result_valid)
        begin
            if (due_beats.size() == 0)
            begin
                $error("unexpected beat: kind %0d woken_id %0d tick_count %0d",
                       kind, woken_id, tick_count);
                mismatches++;
            end
            else
            begin
                want = due_beats.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    mismatches++;
                end
                if (woken_id !== want.id)
                begin
                    $error("woken_id: expected %0d, actual %0d", want.id, woken_id);
                    mismatches++;
                end
                if (tick_count !== want.count)
                begin
                    $error("tick_count: expected %0d, actual %0d", want.count, tick_count);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(req_t rt, logic [ID_W-1:0] id, logic [DUR_W-1:0] dur);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= rt;
        task_id  <= id;
        duration <= dur;
        do
            @(posedge clk);
        while (busy);
        forecast_beats(rt, id, dur);
    endtask

    task automatic settle_queue();
        start <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(logic [TPS_W-1:0] rate);
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tps_now = rate;
    endtask

    // Fill the list with sleepers due at once, overflow it, then wake all in one tick.
    task automatic test_full_list();
        logic [ID_W-1:0] id;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (i == 0)
                id = '0;
            else if (i == 1)
                id = {ID_W{1'b1}};
            else
                id = ID_W'($urandom);
            send_item(i[0] ? REQ_SLEEP_SEC : REQ_SLEEP_TCK, id, '0);
        end
        send_item(REQ_SLEEP_SEC, ID_W'($urandom), DUR_W'($urandom));
        send_item(REQ_TICK, ID_W'($urandom), DUR_W'($urandom));
        send_item(REQ_TICK, ID_W'($urandom), DUR_W'($urandom));
    endtask

    // With a zero rate a seconds request sleeps zero ticks and leaves the list mid-entry.
    task automatic test_zero_rate();
        settle_queue();
        write_rate('0);
        send_item(REQ_SLEEP_TCK, ID_W'($urandom), 32'd2);
        send_item(REQ_SLEEP_SEC, ID_W'($urandom), {DUR_W{1'b1}});
        send_item(REQ_SLEEP_TCK, ID_W'($urandom), 32'd2);
        send_item(REQ_TICK, ID_W'($urandom), DUR_W'($urandom));
        send_item(REQ_TICK, ID_W'($urandom), DUR_W'($urandom));
    endtask

    // The two longest sleeps stay in the list for the rest of the run.
    task automatic test_max_rate();
        settle_queue();
        write_rate({TPS_W{1'b1}});
        send_item(REQ_SLEEP_SEC, {ID_W{1'b1}}, {DUR_W{1'b1}});
        send_item(REQ_SLEEP_TCK, ID_W'($urandom), {DUR_W{1'b1}});
        send_item(REQ_NONE, ID_W'($urandom), DUR_W'($urandom));
        send_item(REQ_SLEEP_SEC, ID_W'($urandom), '0);
        send_item(REQ_TICK, ID_W'($urandom), DUR_W'($urandom));
    endtask

    task automatic test_random_traffic(int unsigned items, logic [TPS_W-1:0] rate,
                                       bit idle_gaps);
        int unsigned sent;
        int unsigned pick;
        logic [DUR_W-1:0] dur;
        settle_queue();
        write_rate(rate);
        gaps_on = idle_gaps;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
            begin
                send_item(REQ_TICK, ID_W'($urandom), DUR_W'($urandom));
                sent++;
            end
            else if (pick < 68)
            begin
                if ($urandom_range(0, 4) == 0)
                    dur = $urandom_range(13, 60);
                else
                    dur = $urandom_range(0, 12);
                send_item(REQ_SLEEP_TCK, ID_W'($urandom), dur);
                sent++;
            end
            else if (pick < 93)
            begin
                send_item(REQ_SLEEP_SEC, ID_W'($urandom), $urandom_range(0, 6));
                sent++;
            end
            else
            begin
                send_item(REQ_NONE, ID_W'($urandom), DUR_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_full_list();
        test_zero_rate();
        test_max_rate();
        test_random_traffic(50, TPS_W'($urandom_range(1, 4)), 1'b1);
        test_random_traffic(40, 16'd1, 1'b0);
        test_random_traffic(40, 16'd3, 1'b1);
        settle_queue();
        if (mismatches == 0)
            $display("tick_sleep_queue_tb: PASS");
        else
            $display("tick_sleep_queue_tb: FAIL");
        $finish;
    end

endmodule
